// File: hdl/rlcc_pkg.sv
// Package for the radial lobe cluster counter: constants, register indexes,
// the verdict codes and the command and status structs shared by all modules.
// Depends on nothing.
package rlcc_pkg;

  localparam int unsigned COUNT_WIDTH_DEF = 16;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned OUT_W = 16;
  localparam int unsigned MAG_W = 21;
  localparam int unsigned SUM_W = 40;
  localparam int unsigned LEN_W = 16;
  localparam int unsigned ROOT_STEPS = 33;
  localparam int unsigned ITER_W = 6;

  localparam logic [CFG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_PIX_PER_UNIT = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_ENTERED = 3'd4;

  localparam logic [31:0] PPU_RESET = 32'h0001_0000;
  localparam logic [MAG_W-1:0] HALF_PIXEL = 21'd32768;
  localparam logic [MAG_W-1:0] FAR_PIXELS = 21'd1966080;

  typedef enum logic [1:0] {
    VERDICT_PASS = 2'd0,
    VERDICT_FAIL = 2'd1,
    VERDICT_NO_SPLINE = 2'd2,
    VERDICT_DOUBLE_BROACH = 2'd3
  } verdict_e;

  typedef struct packed {
    logic load;
    logic mul;
    logic add;
    logic root;
    logic dev;
    logic scale;
    logic mag;
    logic upd;
    logic emit;
  } rlcc_cmd_t;

  typedef struct packed {
    logic last;
  } rlcc_sts_t;

endpackage

// File: hdl/rlcc_if.sv
// Request channel interfaces of the radial lobe cluster counter: the edge
// point channel and the result channel, each with valid, ready and payload.
// Depends on nothing.
interface rlcc_point_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] point_x;
  logic signed [31:0] point_y;
  logic               last_point;

  modport source (output valid, output point_x, output point_y, output last_point,
                  input ready);
  modport sink (input valid, input point_x, input point_y, input last_point,
                output ready);
endinterface

interface rlcc_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] lobe_count;
  logic [1:0]  verdict;

  modport source (output valid, output lobe_count, output verdict, input ready);
  modport sink (input valid, input lobe_count, input verdict, output ready);
endinterface

// File: hdl/rlcc_datapath.sv
// Datapath of the radial lobe cluster counter: configuration registers, the
// squared distance, a bit-serial square root, scaling, run tracking and the verdict.
// Depends on rlcc_pkg.
module rlcc_datapath #(
  parameter int unsigned COUNT_WIDTH = rlcc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [rlcc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rlcc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  rlcc_pkg::rlcc_cmd_t              cmd_i,
  output rlcc_pkg::rlcc_sts_t              sts_o,
  input  logic signed [31:0]               point_x_i,
  input  logic signed [31:0]               point_y_i,
  input  logic                             last_point_i,
  output logic [rlcc_pkg::OUT_W-1:0]       lobe_count_o,
  output rlcc_pkg::verdict_e               verdict_o
);
  import rlcc_pkg::*;

  localparam int unsigned VW = COUNT_WIDTH + 14;
  localparam int unsigned TW = COUNT_WIDTH + OUT_W;

  logic signed [31:0] cx_q, cy_q;
  logic [30:0]        radius_q;
  logic [31:0]        ppu_q;
  logic [9:0]         entered_q;

  logic [31:0] ax_q, ay_q;
  logic        last_q;
  logic [63:0] sx_q, sy_q;
  logic [65:0] rad_q;
  logic [33:0] rem_q;
  logic [32:0] root_q;
  logic [32:0] ad_q;
  logic        neg_q;
  logic [48:0] ph_q, pl_q;
  logic [MAG_W-1:0] m_q;
  logic        outside_q, inside_q;

  logic                   run_active_q;
  logic [LEN_W-1:0]       run_len_q;
  logic [SUM_W-1:0]       run_sum_q;
  logic [COUNT_WIDTH-1:0] total_q;

  logic [OUT_W-1:0] lobe_q;
  verdict_e         verdict_q;

  logic [32:0] dx, dy, ax_d, ay_d;
  logic [35:0] rem_sh, trial, rem_nx;
  logic        ge;
  logic [33:0] dev, ad_d;
  logic [49:0] m_full;
  logic        band;
  logic        qualify;
  logic [SUM_W:0] sum_add;
  logic [VW-1:0] c_ext, e_ext, c2, c10, e13;
  logic [TW-1:0] tot_w;
  logic [OUT_W-1:0] lobe_d;
  verdict_e verdict_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q      <= '0;
      cy_q      <= '0;
      radius_q  <= '0;
      ppu_q     <= PPU_RESET;
      entered_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_CENTER_X:     cx_q      <= cfg_data_i;
        REG_CENTER_Y:     cy_q      <= cfg_data_i;
        REG_RADIUS:       radius_q  <= cfg_data_i[30:0];
        REG_PIX_PER_UNIT: ppu_q     <= cfg_data_i;
        REG_ENTERED:      entered_q <= cfg_data_i[9:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    dx      = {point_x_i[31], point_x_i} - {cx_q[31], cx_q};
    dy      = {point_y_i[31], point_y_i} - {cy_q[31], cy_q};
    ax_d    = dx[32] ? (33'd0 - dx) : dx;
    ay_d    = dy[32] ? (33'd0 - dy) : dy;
    rem_sh  = {rem_q, rad_q[65:64]};
    trial   = {1'b0, root_q, 2'b01};
    ge      = (rem_sh >= trial);
    rem_nx  = ge ? (rem_sh - trial) : rem_sh;
    dev     = {1'b0, root_q} - {3'b000, radius_q};
    ad_d    = dev[33] ? (34'd0 - dev) : dev;
    m_full  = {1'b0, ph_q} + {17'd0, pl_q[48:16]};
    band    = (m_full > 50'(HALF_PIXEL)) && (m_full < 50'(FAR_PIXELS));
    qualify = run_active_q && (run_len_q > 16'd3) &&
              (run_sum_q > {9'd0, run_len_q, 15'd0});
    sum_add = {1'b0, run_sum_q} + (SUM_W + 1)'(m_q);
  end

  always_comb begin
    c_ext = VW'(total_q);
    e_ext = VW'(entered_q);
    c2    = c_ext << 1;
    c10   = (c_ext << 3) + (c_ext << 1);
    e13   = (e_ext << 3) + (e_ext << 2) + e_ext;
    priority if (c_ext == e_ext) begin
      verdict_d = VERDICT_PASS;
    end else if (c2 < e_ext) begin
      verdict_d = VERDICT_NO_SPLINE;
    end else if (c10 > e13) begin
      verdict_d = VERDICT_DOUBLE_BROACH;
    end else begin
      verdict_d = VERDICT_FAIL;
    end
    tot_w  = TW'(total_q);
    lobe_d = (tot_w > TW'({OUT_W{1'b1}})) ? {OUT_W{1'b1}} : tot_w[OUT_W-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      ax_q   <= ax_d[31:0];
      ay_q   <= ay_d[31:0];
      last_q <= last_point_i;
    end
    if (cmd_i.mul) begin
      sx_q <= ax_q * ax_q;
      sy_q <= ay_q * ay_q;
    end
    if (cmd_i.add) begin
      rad_q  <= {1'b0, {1'b0, sx_q} + {1'b0, sy_q}};
      rem_q  <= '0;
      root_q <= '0;
    end
    if (cmd_i.root) begin
      rad_q  <= {rad_q[63:0], 2'b00};
      rem_q  <= rem_nx[33:0];
      root_q <= {root_q[31:0], ge};
    end
    if (cmd_i.dev) begin
      ad_q  <= ad_d[32:0];
      neg_q <= dev[33];
    end
    if (cmd_i.scale) begin
      ph_q <= 49'(ad_q) * 49'(ppu_q[31:16]);
      pl_q <= 49'(ad_q) * 49'(ppu_q[15:0]);
    end
    if (cmd_i.mag) begin
      m_q       <= m_full[MAG_W-1:0];
      outside_q <= band && !neg_q;
      inside_q  <= band && neg_q;
    end
    if (cmd_i.emit) begin
      lobe_q    <= lobe_d;
      verdict_q <= verdict_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_active_q <= 1'b0;
      run_len_q    <= '0;
      run_sum_q    <= '0;
      total_q      <= '0;
    end else if (cmd_i.emit) begin
      run_active_q <= 1'b0;
      run_len_q    <= '0;
      run_sum_q    <= '0;
      total_q      <= '0;
    end else if (cmd_i.upd) begin
      if (inside_q) begin
        if (qualify && (total_q != {COUNT_WIDTH{1'b1}})) begin
          total_q <= total_q + 1'b1;
        end
        run_active_q <= 1'b0;
        run_len_q    <= '0;
        run_sum_q    <= '0;
      end else if (outside_q) begin
        run_active_q <= 1'b1;
        run_sum_q    <= sum_add[SUM_W] ? {SUM_W{1'b1}} : sum_add[SUM_W-1:0];
        if (run_len_q != {LEN_W{1'b1}}) begin
          run_len_q <= run_len_q + 1'b1;
        end
      end
    end
  end

  assign sts_o.last   = last_q;
  assign lobe_count_o = lobe_q;
  assign verdict_o    = verdict_q;

  ap_idle_run_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !run_active_q |-> (run_len_q == '0) && (run_sum_q == '0))
    else $error("run counters not empty while no run is open");

  ap_emit_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |=> (total_q == '0) && !run_active_q)
    else $error("contour state not cleared after a result");

  ap_inside_closes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.upd && inside_q && !cmd_i.emit) |=> !run_active_q)
    else $error("inside point did not close the run");
endmodule

// File: hdl/rlcc_ctrl.sv
// Controller of the radial lobe cluster counter: sequences one point through
// the datapath steps and owns the input ready and the result valid flag.
// Depends on rlcc_pkg.
module rlcc_ctrl (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  input  rlcc_pkg::rlcc_sts_t sts_i,
  output rlcc_pkg::rlcc_cmd_t cmd_o
);
  import rlcc_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_ADD   = 4'd2;
  localparam logic [3:0] ST_ROOT  = 4'd3;
  localparam logic [3:0] ST_DEV   = 4'd4;
  localparam logic [3:0] ST_SCALE = 4'd5;
  localparam logic [3:0] ST_MAG   = 4'd6;
  localparam logic [3:0] ST_UPD   = 4'd7;
  localparam logic [3:0] ST_EMIT  = 4'd8;

  logic [3:0]        state_q, state_d;
  logic [ITER_W-1:0] iter_q, iter_d;
  logic              out_valid_q, out_valid_d;

  always_comb begin
    state_d     = state_q;
    iter_d      = iter_q;
    cmd_o       = '0;
    in_ready_o  = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = ST_ADD;
      end
      ST_ADD: begin
        cmd_o.add = 1'b1;
        iter_d    = ITER_W'(ROOT_STEPS - 1);
        state_d   = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root = 1'b1;
        if (iter_q == '0) begin
          state_d = ST_DEV;
        end else begin
          iter_d = iter_q - 1'b1;
        end
      end
      ST_DEV: begin
        cmd_o.dev = 1'b1;
        state_d   = ST_SCALE;
      end
      ST_SCALE: begin
        cmd_o.scale = 1'b1;
        state_d     = ST_MAG;
      end
      ST_MAG: begin
        cmd_o.mag = 1'b1;
        state_d   = ST_UPD;
      end
      ST_UPD: begin
        cmd_o.upd = 1'b1;
        state_d   = sts_i.last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.emit = 1'b1;
          state_d    = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
    if (cmd_o.emit) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      iter_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      iter_q      <= iter_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

  ap_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == ST_MUL) && !in_ready_o)
    else $error("accepted point did not start the multiply step");

  ap_root_length: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ADD) |-> ##34 (state_q == ST_DEV))
    else $error("square root did not take the expected number of steps");

  ap_emit_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.emit |=> out_valid_q)
    else $error("result loaded but not shown as valid");
endmodule

// File: hdl/radial_lobe_cluster_counter.sv
// Radial lobe cluster counter, top level. A new point is accepted only after the previous
// one has passed all datapath steps, among them a 33-step bit-serial square root of the
// 65-bit squared distance. A last point's result enters the output register once any
// earlier result has been taken, and waits there while the next point is taken.
// Reset (asynchronous, active low) clears the run, the count and the result valid;
// configuration returns to centre 0, radius 0, scale 1.0 and expected count 0.
module radial_lobe_cluster_counter #(
  parameter int unsigned COUNT_WIDTH = rlcc_pkg::COUNT_WIDTH_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rlcc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rlcc_pkg::CFG_DATA_W-1:0] cfg_data_i,
  rlcc_point_if.sink                      point_i,
  rlcc_result_if.source                   result_o
);
  import rlcc_pkg::*;

  rlcc_cmd_t cmd;
  rlcc_sts_t sts;
  logic      in_ready;
  logic      out_valid;
  logic [OUT_W-1:0] lobe_count;
  verdict_e  verdict;

  rlcc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (point_i.valid),
    .in_ready_o  (in_ready),
    .out_valid_o (out_valid),
    .out_ready_i (result_o.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  rlcc_datapath #(
    .COUNT_WIDTH (COUNT_WIDTH)
  ) u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .point_x_i    (point_i.point_x),
    .point_y_i    (point_i.point_y),
    .last_point_i (point_i.last_point),
    .lobe_count_o (lobe_count),
    .verdict_o    (verdict)
  );

  assign point_i.ready       = in_ready;
  assign result_o.valid      = out_valid;
  assign result_o.lobe_count = lobe_count;
  assign result_o.verdict    = verdict;
endmodule
